>>> rtl/ofem_pkg.sv
`default_nettype none

package ofem_pkg;

    localparam int FRAME_MAX      = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAME_LOG2_MAX = $clog2(FRAME_MAX);
    localparam int FL_MIN         = 4;
    localparam int FL_W           = $clog2(FRAME_LOG2_MAX + 1);
    localparam int ADDR_W         = FRAME_LOG2_MAX;
    localparam int LEN_W          = FRAME_LOG2_MAX + 1;
    localparam int HOP_CFG_W      = 11;
    localparam int CNT_W          = (LEN_W > HOP_CFG_W) ? LEN_W : HOP_CFG_W;
    localparam int SKIP_W         = 16;

    localparam int SQ_W           = 2 * SAMPLE_BITS - 1;
    localparam int DIFF_W         = SQ_W + 1;
    localparam int SUM_W          = SQ_W + FRAME_LOG2_MAX;
    localparam int Q_FRAC         = 2 * (SAMPLE_BITS - 1);
    localparam int SH_R           = (Q_FRAC >= 30) ? Q_FRAC - 30 : 0;
    localparam int SH_L           = (Q_FRAC >= 30) ? 0 : 30 - Q_FRAC;
    localparam int QW             = SUM_W + SH_L;
    localparam int MEAN_W         = 31;
    localparam int LEVEL_W        = 32;

    localparam int Q_DEPTH        = 8;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    localparam int SQ_STEPS       = 16;
    localparam int STEP_W         = $clog2(SQ_STEPS);
    localparam int SHIFT_W        = 5;
    localparam int NEG_W          = SHIFT_W + SQ_STEPS;
    localparam int PROD_W         = 39;

    localparam logic [17:0]        TEN_LOG10_2_Q16  = 18'd197284;
    localparam logic [23:0]        TEN_LOG10_96_Q16 = 24'd1299101;
    localparam logic [LEVEL_W-1:0] DB_FLOOR         = 32'hFFFF_A000;
    localparam logic [MEAN_W-1:0]  MEAN_MAX         = 31'h4000_0000;

    localparam int REG_COUNT  = 4;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int APB_AW     = REG_IDX_W + 2;
    localparam int APB_DW     = 32;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_LOG2   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOP_LENGTH   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINEAR_SCALE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_SKIP   = 2'd3;

    localparam logic [3:0]           RST_FRAME_LOG2   = 4'd10;
    localparam logic [HOP_CFG_W-1:0] RST_HOP_LENGTH   = 11'd512;

    typedef struct packed {
        logic [3:0]           frame_log2;
        logic [HOP_CFG_W-1:0] hop_length;
        logic                 linear_scale;
        logic [SKIP_W-1:0]    start_skip;
    } t_cfg;

    typedef struct packed {
        logic                     emit;
        logic signed [DIFF_W-1:0] diff;
    } t_q_item;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_front_stat;

    typedef struct packed {
        logic              valid;
        logic              linear;
        logic [MEAN_W-1:0] mean;
    } t_db_job;

    function automatic logic [FL_W-1:0] frame_shift(input logic [3:0] fl_cfg);
        int v;
        v = int'(fl_cfg);
        if (v < FL_MIN) v = FL_MIN;
        if (v > FRAME_LOG2_MAX) v = FRAME_LOG2_MAX;
        return FL_W'(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ofem_if.sv
`default_nettype none

interface ofem_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ofem_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ofem_level_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ofem_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

>>> rtl/ofem_front.sv
`default_nettype none

module ofem_front (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire ofem_pkg::t_cfg                           i_cfg,
    input  wire logic                                     i_restart,
    input  wire logic                                     i_accept,
    input  wire logic signed [ofem_pkg::SAMPLE_BITS-1:0]  i_sample,
    output      logic                                     o_push,
    output      ofem_pkg::t_q_item                        o_push_item,
    output      ofem_pkg::t_front_stat                    o_stat
);

    logic [ofem_pkg::SAMPLE_BITS-1:0] r_ring [ofem_pkg::FRAME_MAX];
    logic [ofem_pkg::SAMPLE_BITS-1:0] r_old;

    logic [ofem_pkg::SKIP_W-1:0] r_skip;
    logic [ofem_pkg::ADDR_W-1:0] r_slot, n_slot;
    logic [ofem_pkg::CNT_W-1:0]  r_fill, n_fill;
    logic [ofem_pkg::CNT_W-1:0]  r_hop, n_hop;

    logic                                    r_a_valid, r_a_sub, r_a_emit;
    logic signed [ofem_pkg::SAMPLE_BITS-1:0] r_a_new;
    logic                                    r_b_valid, r_b_emit;
    logic signed [ofem_pkg::DIFF_W-1:0]      r_b_diff;

    logic                              skipping, take, emit, sub;
    logic [ofem_pkg::FL_W-1:0]         fl;
    logic [ofem_pkg::CNT_W-1:0]        len_c, hop_c, hop_x;
    logic [ofem_pkg::ADDR_W-1:0]       slot;
    logic signed [2*ofem_pkg::SAMPLE_BITS-1:0] prod_new, prod_old;
    logic [ofem_pkg::SQ_W-1:0]         sq_new, sq_old;

    assign skipping = r_skip < i_cfg.start_skip;
    assign take     = i_accept && !skipping;
    assign fl       = ofem_pkg::frame_shift(i_cfg.frame_log2);
    assign len_c    = ofem_pkg::CNT_W'(1) << fl;
    assign slot     = r_slot & ofem_pkg::ADDR_W'(len_c - ofem_pkg::CNT_W'(1));
    assign hop_x    = ofem_pkg::CNT_W'(i_cfg.hop_length);
    assign sub      = r_fill >= len_c;

    always_comb begin
        hop_c = hop_x;
        if (hop_c == '0) hop_c = ofem_pkg::CNT_W'(1);
        if (hop_c > len_c) hop_c = len_c;
    end

    always_comb begin
        n_slot = ofem_pkg::ADDR_W'((slot + ofem_pkg::ADDR_W'(1))
                 & ofem_pkg::ADDR_W'(len_c - ofem_pkg::CNT_W'(1)));
        n_fill = r_fill;
        n_hop  = r_hop;
        emit   = 1'b0;
        if (!sub) begin
            n_fill = r_fill + ofem_pkg::CNT_W'(1);
            if (n_fill == len_c) begin
                emit  = 1'b1;
                n_hop = '0;
            end
        end else begin
            n_hop = r_hop + ofem_pkg::CNT_W'(1);
            if (n_hop >= hop_c) begin
                emit  = 1'b1;
                n_hop = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_old        <= r_ring[slot];
            r_ring[slot] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip    <= '0;
            r_slot    <= '0;
            r_fill    <= '0;
            r_hop     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_accept && skipping) r_skip <= r_skip + ofem_pkg::SKIP_W'(1);
            if (i_restart) begin
                r_slot <= '0;
                r_fill <= '0;
                r_hop  <= '0;
            end else if (take) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
                r_hop  <= n_hop;
            end
            r_a_valid <= take;
            r_b_valid <= r_a_valid;
        end
    end

    assign prod_new = r_a_new * r_a_new;
    assign prod_old = $signed(r_old) * $signed(r_old);
    assign sq_new   = prod_new[ofem_pkg::SQ_W-1:0];
    assign sq_old   = r_a_sub ? prod_old[ofem_pkg::SQ_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_new  <= i_sample;
            r_a_sub  <= sub;
            r_a_emit <= emit;
        end
        if (r_a_valid) begin
            r_b_emit <= r_a_emit;
            r_b_diff <= $signed({1'b0, sq_new}) - $signed({1'b0, sq_old});
        end
    end

    assign o_push           = r_b_valid;
    assign o_push_item.emit = r_b_emit;
    assign o_push_item.diff = r_b_diff;
    assign o_stat.a_valid   = r_a_valid;
    assign o_stat.b_valid   = r_b_valid;

endmodule

`default_nettype wire

>>> rtl/ofem_fifo.sv
`default_nettype none

module ofem_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ofem_pkg::t_q_item i_item,
    input  wire logic              i_pop,
    output      ofem_pkg::t_q_item o_item,
    output      ofem_pkg::t_q_stat o_stat
);

    ofem_pkg::t_q_item r_mem [ofem_pkg::Q_DEPTH];

    logic [ofem_pkg::Q_PTR_W-1:0] r_wr, r_rd;
    logic [ofem_pkg::Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + ofem_pkg::Q_PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + ofem_pkg::Q_PTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + ofem_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - ofem_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = r_count == '0;
    assign o_stat.full  = r_count == ofem_pkg::Q_CNT_W'(ofem_pkg::Q_DEPTH);

endmodule

`default_nettype wire

>>> rtl/ofem_accum.sv
`default_nettype none

module ofem_accum (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ofem_pkg::t_cfg    i_cfg,
    input  wire logic              i_restart,
    input  wire ofem_pkg::t_q_item i_item,
    input  wire logic              i_empty,
    output      logic              o_pop,
    output      ofem_pkg::t_db_job o_job,
    input  wire logic              i_job_ready
);

    logic [ofem_pkg::SUM_W-1:0] r_sum;
    logic                       r_pend;

    logic [ofem_pkg::FL_W-1:0]  fl;
    logic [ofem_pkg::SUM_W-1:0] mean_raw;
    logic [ofem_pkg::QW-1:0]    mean_q;

    assign fl       = ofem_pkg::frame_shift(i_cfg.frame_log2);
    assign o_pop    = !i_empty && (!r_pend || i_job_ready);
    assign mean_raw = r_sum >> fl;
    assign mean_q   = ofem_pkg::QW'(mean_raw >> ofem_pkg::SH_R) << ofem_pkg::SH_L;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pend <= 1'b0;
        end else if (i_restart) begin
            r_sum  <= '0;
            r_pend <= 1'b0;
        end else if (o_pop) begin
            r_sum  <= r_sum + ofem_pkg::SUM_W'(i_item.diff);
            r_pend <= i_item.emit;
        end else if (i_job_ready) begin
            r_pend <= 1'b0;
        end
    end

    assign o_job.valid  = r_pend;
    assign o_job.linear = i_cfg.linear_scale;
    assign o_job.mean   = (mean_q > ofem_pkg::QW'(ofem_pkg::MEAN_MAX))
                          ? ofem_pkg::MEAN_MAX : mean_q[ofem_pkg::MEAN_W-1:0];

endmodule

`default_nettype wire

>>> rtl/ofem_db.sv
`default_nettype none

module ofem_db (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ofem_pkg::t_db_job i_job,
    output      logic              o_job_ready,
    ofem_level_if.source           o_level_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SQR,
        S_MUL,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;

    logic [ofem_pkg::MEAN_W-1:0]   r_x;
    logic [ofem_pkg::SHIFT_W-1:0]  r_s;
    logic [ofem_pkg::SQ_STEPS-1:0] r_frac;
    logic [ofem_pkg::STEP_W-1:0]   r_i;
    logic [ofem_pkg::PROD_W-1:0]   r_prod;
    logic [ofem_pkg::LEVEL_W-1:0]  r_res;
    logic                          r_out_valid;
    logic [ofem_pkg::LEVEL_W-1:0]  r_out_level;

    logic [2*ofem_pkg::MEAN_W-1:0] sq;
    logic [ofem_pkg::MEAN_W:0]     sq_q;
    logic [ofem_pkg::NEG_W-1:0]    neg;
    logic [ofem_pkg::PROD_W:0]     rnd;
    logic [23:0]                   mag;
    logic [23:0]                   mag_r;
    logic                          out_free;

    assign sq       = r_x * r_x;
    assign sq_q     = sq[2*ofem_pkg::MEAN_W-1:30];
    assign neg      = {r_s, {ofem_pkg::SQ_STEPS{1'b0}}} - ofem_pkg::NEG_W'(r_frac);
    assign rnd      = ofem_pkg::PROD_W'(r_prod) + (ofem_pkg::PROD_W + 1)'(32768);
    assign mag      = 24'(rnd >> 16) + ofem_pkg::TEN_LOG10_96_Q16;
    assign mag_r    = (mag + 24'd128) >> 8;
    assign out_free = !r_out_valid || o_level_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_level_ch.ready && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job.valid) begin
                        r_x    <= i_job.mean;
                        r_s    <= '0;
                        r_frac <= '0;
                        r_i    <= '0;
                        if (i_job.linear) begin
                            r_res   <= ofem_pkg::LEVEL_W'(i_job.mean);
                            r_state <= S_DONE;
                        end else if (i_job.mean == '0) begin
                            r_res   <= ofem_pkg::DB_FLOOR;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (r_x[ofem_pkg::MEAN_W-1]) begin
                        r_state <= S_SQR;
                    end else if (r_x[ofem_pkg::MEAN_W-1 -: 8] == '0) begin
                        r_x <= r_x << 8;
                        r_s <= r_s + ofem_pkg::SHIFT_W'(8);
                    end else begin
                        r_x <= r_x << 1;
                        r_s <= r_s + ofem_pkg::SHIFT_W'(1);
                    end
                end
                S_SQR: begin
                    if (sq_q[ofem_pkg::MEAN_W]) begin
                        r_x    <= sq_q[ofem_pkg::MEAN_W:1];
                        r_frac <= {r_frac[ofem_pkg::SQ_STEPS-2:0], 1'b1};
                    end else begin
                        r_x    <= sq_q[ofem_pkg::MEAN_W-1:0];
                        r_frac <= {r_frac[ofem_pkg::SQ_STEPS-2:0], 1'b0};
                    end
                    r_i <= r_i + ofem_pkg::STEP_W'(1);
                    if (r_i == ofem_pkg::STEP_W'(ofem_pkg::SQ_STEPS - 1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= ofem_pkg::PROD_W'(neg * ofem_pkg::TEN_LOG10_2_Q16);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res   <= ofem_pkg::LEVEL_W'(0) - ofem_pkg::LEVEL_W'(mag_r);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_job_ready      = r_state == S_IDLE;
    assign o_level_ch.valid = r_out_valid;
    assign o_level_ch.level = r_out_level;

endmodule

`default_nettype wire

>>> rtl/overlapped_frame_energy_meter_top.sv
// Channel      Dir   Payload               Transaction
// i_sample_ch  in    sample  s16 Q1.15     valid && ready
// o_level_ch   out   level   s32           valid && ready
// APB          in    4 regs at 4*i         psel && penable && pwrite
//
// Takes one sample per cycle; ready drops only when the sample queue and the
// two squaring stages ahead of it hold eight transactions.
// A linear result is presented after the squaring stages, the queue, the accumulator
// and the log unit; a decibel result occupies the log unit through accept, normalize,
// 16 squarings, scale, output, which bounds the result rate when the hop is shorter.
// Reset is synchronous, active low; the sample ring needs no clearing pass.
// A stalled output holds its result while the next one is being computed.
`default_nettype none

module overlapped_frame_energy_meter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ofem_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ofem_pkg::APB_DW-1:0]   pwdata,
    output      logic [ofem_pkg::APB_DW-1:0]   prdata,
    output      logic                          pready,
    ofem_sample_if.sink                        i_sample_ch,
    ofem_level_if.source                       o_level_ch
);

    ofem_pkg::t_cfg        r_cfg;
    ofem_pkg::t_q_item     push_item, pop_item;
    ofem_pkg::t_q_stat     q_stat;
    ofem_pkg::t_front_stat front_stat;
    ofem_pkg::t_db_job     job;

    logic                            cfg_wr, restart, accept, q_push, q_pop, job_ready;
    logic [ofem_pkg::REG_IDX_W-1:0]  reg_idx;
    logic [ofem_pkg::Q_CNT_W:0]      in_flight;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ofem_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && (reg_idx == ofem_pkg::REG_FRAME_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_log2   <= ofem_pkg::RST_FRAME_LOG2;
            r_cfg.hop_length   <= ofem_pkg::RST_HOP_LENGTH;
            r_cfg.linear_scale <= 1'b0;
            r_cfg.start_skip   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                ofem_pkg::REG_FRAME_LOG2:   r_cfg.frame_log2   <= pwdata[3:0];
                ofem_pkg::REG_HOP_LENGTH:
                    r_cfg.hop_length <= pwdata[ofem_pkg::HOP_CFG_W-1:0];
                ofem_pkg::REG_LINEAR_SCALE: r_cfg.linear_scale <= pwdata[0];
                ofem_pkg::REG_START_SKIP:
                    r_cfg.start_skip <= pwdata[ofem_pkg::SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ofem_pkg::REG_FRAME_LOG2:   prdata = ofem_pkg::APB_DW'(r_cfg.frame_log2);
            ofem_pkg::REG_HOP_LENGTH:   prdata = ofem_pkg::APB_DW'(r_cfg.hop_length);
            ofem_pkg::REG_LINEAR_SCALE: prdata = ofem_pkg::APB_DW'(r_cfg.linear_scale);
            ofem_pkg::REG_START_SKIP:   prdata = ofem_pkg::APB_DW'(r_cfg.start_skip);
            default:                    prdata = '0;
        endcase
    end

    // reserve queue room for every transaction still in the squaring stages
    assign in_flight = (ofem_pkg::Q_CNT_W + 1)'(q_stat.count)
                     + (ofem_pkg::Q_CNT_W + 1)'(front_stat.a_valid)
                     + (ofem_pkg::Q_CNT_W + 1)'(front_stat.b_valid);
    assign i_sample_ch.ready = in_flight < (ofem_pkg::Q_CNT_W + 1)'(ofem_pkg::Q_DEPTH);
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;

    ofem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (restart),
        .i_accept    (accept),
        .i_sample    (i_sample_ch.sample),
        .o_push      (q_push),
        .o_push_item (push_item),
        .o_stat      (front_stat)
    );

    ofem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    ofem_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (restart),
        .i_item      (pop_item),
        .i_empty     (q_stat.empty),
        .o_pop       (q_pop),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    ofem_db u_db (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_level_ch  (o_level_ch)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> in_flight <= (ofem_pkg::Q_CNT_W + 1)'(ofem_pkg::Q_DEPTH))
        else $error("sample accepted without queue room");

endmodule

`default_nettype wire
